@@ hw/rtl/fple_pkg.sv @@
// ----------------------------------------------------------------------------
// Fuel-per-lap estimator package
// Shared widths, payload types, register indexes and the command and status
// types that join the controller and the datapath.
// ----------------------------------------------------------------------------
package fple_pkg;

	localparam int FUEL_BITS  = 20;
	localparam int SPEED_W    = 13;
	localparam int LAP_W      = 16;
	localparam int INST_W     = 28;
	localparam int USE_W      = 20;
	localparam int LEFT_W     = 16;
	localparam int WEIGHT_W   = 9;
	localparam int RATE_W     = 8;
	localparam int FRAC_W     = 8;
	localparam int SAT_SH     = LEFT_W - FRAC_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int MUL_A_W = FUEL_BITS;
	localparam int MUL_B_W = WEIGHT_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam int DIV_STEPS = LEFT_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE    = WEIGHT_W'(256);
	localparam logic [WEIGHT_W-1:0]   EMA_WEIGHT_RST = WEIGHT_W'(77);
	localparam logic [SPEED_W-1:0]    PIT_SPEED_RST = SPEED_W'(80);
	localparam logic [RATE_W-1:0]     RATE_RST      = RATE_W'(60);
	localparam logic [PROD_W:0]       EMA_ROUND     = (PROD_W + 1)'(128);

	localparam logic [CFG_IDX_W-1:0] CFG_EMA_WEIGHT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIT_EXIT_SPEED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE    = 2'd2;

	// Multiplier operand selection.
	localparam logic [1:0] MUL_DROP = 2'd0;
	localparam logic [1:0] MUL_AVG  = 2'd1;
	localparam logic [1:0] MUL_LAP  = 2'd2;

	// Datapath operations.
	localparam logic [3:0] OP_NONE      = 4'd0;
	localparam logic [3:0] OP_FIRST     = 4'd1;
	localparam logic [3:0] OP_REFUEL    = 4'd2;
	localparam logic [3:0] OP_PIT_EXIT  = 4'd3;
	localparam logic [3:0] OP_LAP_SEED  = 4'd4;
	localparam logic [3:0] OP_LAP_CLOSE = 4'd5;
	localparam logic [3:0] OP_EMA_ACC   = 4'd6;
	localparam logic [3:0] OP_EMA_DONE  = 4'd7;
	localparam logic [3:0] OP_LEFT_ZERO = 4'd8;
	localparam logic [3:0] OP_LEFT_SAT  = 4'd9;
	localparam logic [3:0] OP_DIV_INIT  = 4'd10;
	localparam logic [3:0] OP_DIV_STEP  = 4'd11;

	typedef struct packed {
		logic [FUEL_BITS-1:0] fuel_level;
		logic [SPEED_W-1:0]   speed;
		logic [LAP_W-1:0]     lap_number;
	} sample_t;

	typedef struct packed {
		logic [INST_W-1:0] instant_use;
		logic [USE_W-1:0]  lap_use;
		logic [LEFT_W-1:0] laps_left;
		logic              laps_known;
		logic              refuelling;
	} result_t;

	typedef struct packed {
		logic       in_load;
		logic [3:0] op;
		logic [1:0] mul_sel;
		logic       inst_take;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic primed;
		logic fuel_rise;
		logic pit_exit;
		logic new_lap;
		logic lap_drop;
		logic avg_nz;
		logic lap_sat;
		logic out_free;
	} status_t;

endpackage

@@ hw/rtl/fple_sample_if.sv @@
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one telemetry sample per request.
// ----------------------------------------------------------------------------
interface fple_sample_if import fple_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/fple_result_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one estimate per request.
// ----------------------------------------------------------------------------
interface fple_result_if import fple_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/fuel_per_lap_estimator.sv @@
// ----------------------------------------------------------------------------
// Fuel-per-lap estimator
// Instantaneous fuel use, averaged use per lap and laps of fuel left from
// a stream of telemetry samples.
//
//   Channel   Dir   Payload                                          Request
//   sample    in    fuel_level, speed, lap_number                    valid & ready
//   result    out   instant_use, lap_use, laps_left, laps_known,     valid & ready
//                   refuelling
//   cfg       in    cfg_index, cfg_data                              cfg_we
//
// A sample is taken only while the controller is idle. A normal sample goes
// through check, instant use, divide check, the 16-step laps-left divider and
// emit, plus the average states on an average update. The first sample and a
// refuel sample go straight to emit; a sample with no average or a saturated
// result skips the divider. One finished result waits in the output register
// while the next sample is processed; a stalled result only holds back the
// one after it. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module fuel_per_lap_estimator import fple_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	fple_sample_if.sink           sample,
	fple_result_if.source         result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t st;

	fple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.st       (st),
		.cmd      (cmd)
	);

	fple_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (sample.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (result.data),
		.out_valid (result.valid),
		.out_ready (result.ready)
	);

endmodule

@@ hw/rtl/fple_ctrl.sv @@
// ----------------------------------------------------------------------------
// Estimator controller
// Sequences one sample through the check, multiply, average and divide steps
// and issues one datapath operation per cycle.
// ----------------------------------------------------------------------------
module fple_ctrl import fple_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_INST   = 3'd2;
	localparam logic [2:0] S_EMA1   = 3'd3;
	localparam logic [2:0] S_EMA2   = 3'd4;
	localparam logic [2:0] S_DIVCHK = 3'd5;
	localparam logic [2:0] S_DIV    = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	logic [2:0]       state_q;
	logic [2:0]       state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_nxt     = state_q;
		cnt_nxt       = cnt_q;
		cmd.in_load   = 1'b0;
		cmd.op        = OP_NONE;
		cmd.mul_sel   = MUL_DROP;
		cmd.inst_take = 1'b0;
		cmd.out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_nxt   = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.mul_sel = MUL_DROP;
				if (!st.primed) begin
					cmd.op    = OP_FIRST;
					state_nxt = S_EMIT;
				end else if (st.fuel_rise) begin
					cmd.op    = OP_REFUEL;
					state_nxt = S_EMIT;
				end else begin
					cmd.op    = st.pit_exit ? OP_PIT_EXIT : OP_NONE;
					state_nxt = S_INST;
				end
			end
			S_INST: begin
				cmd.inst_take = 1'b1;
				cmd.mul_sel   = MUL_AVG;
				if (st.new_lap && st.lap_drop && st.avg_nz) begin
					state_nxt = S_EMA1;
				end else begin
					if (st.new_lap) begin
						cmd.op = st.lap_drop ? OP_LAP_SEED : OP_LAP_CLOSE;
					end
					state_nxt = S_DIVCHK;
				end
			end
			S_EMA1: begin
				cmd.op      = OP_EMA_ACC;
				cmd.mul_sel = MUL_LAP;
				state_nxt   = S_EMA2;
			end
			S_EMA2: begin
				cmd.op    = OP_EMA_DONE;
				state_nxt = S_DIVCHK;
			end
			S_DIVCHK: begin
				if (!st.avg_nz) begin
					cmd.op    = OP_LEFT_ZERO;
					state_nxt = S_EMIT;
				end else if (st.lap_sat) begin
					cmd.op    = OP_LEFT_SAT;
					state_nxt = S_EMIT;
				end else begin
					cmd.op    = OP_DIV_INIT;
					cnt_nxt   = CNT_W'(DIV_STEPS - 1);
					state_nxt = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (cnt_q == '0) begin
					state_nxt = S_EMIT;
				end else begin
					cnt_nxt = cnt_q - 1'b1;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

endmodule

@@ hw/rtl/fple_dp.sv @@
// ----------------------------------------------------------------------------
// Estimator datapath
// Configuration and tracking registers, a shared 20x9 multiplier, the lap
// average update, a radix-2 divider for laps left and the result register.
// ----------------------------------------------------------------------------
module fple_dp import fple_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               st,
	input  sample_t               in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output result_t               out_data,
	output logic                  out_valid,
	input  logic                  out_ready
);

	logic [WEIGHT_W-1:0]  ema_weight_q;
	logic [SPEED_W-1:0]   pit_speed_q;
	logic [RATE_W-1:0]    rate_q;

	logic [FUEL_BITS-1:0] fuel_q;
	logic [SPEED_W-1:0]   speed_q;
	logic [LAP_W-1:0]     lap_q;

	logic                 primed_q;
	logic [FUEL_BITS-1:0] last_fuel_q;
	logic [FUEL_BITS-1:0] lap_start_q;
	logic [LAP_W-1:0]     last_lap_q;
	logic                 refuel_q;
	logic [FUEL_BITS-1:0] avg_q;
	logic [LEFT_W-1:0]    left_q;
	logic                 known_q;

	logic [PROD_W-1:0]    prod_q;
	logic [PROD_W-1:0]    acc_q;
	logic [INST_W-1:0]    inst_q;
	logic [FUEL_BITS-1:0] rem_q;
	logic [LEFT_W-1:0]    dvd_q;
	result_t              out_q;
	logic                 out_valid_q;

	logic [FUEL_BITS-1:0] drop;
	logic [FUEL_BITS-1:0] lap_d;
	logic [WEIGHT_W-1:0]  w_clamp;
	logic [WEIGHT_W-1:0]  w_inv;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [PROD_W:0]      ema_sum;
	logic [FUEL_BITS-1:0] avg_new;
	logic [FUEL_BITS:0]   trial;
	logic [FUEL_BITS:0]   diff;
	logic                 fits;

	assign drop    = last_fuel_q - fuel_q;
	assign lap_d   = lap_start_q - fuel_q;
	assign w_clamp = (ema_weight_q > WEIGHT_ONE) ? WEIGHT_ONE : ema_weight_q;
	assign w_inv   = WEIGHT_ONE - w_clamp;

	always_comb begin
		case (cmd.mul_sel)
			MUL_DROP: begin
				mul_a = drop;
				mul_b = MUL_B_W'(rate_q);
			end
			MUL_AVG: begin
				mul_a = avg_q;
				mul_b = w_inv;
			end
			MUL_LAP: begin
				mul_a = lap_d;
				mul_b = w_clamp;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Weighted sum of the old average and the new lap, rounded half up.
	assign ema_sum = (PROD_W + 1)'(acc_q) + (PROD_W + 1)'(prod_q) + EMA_ROUND;
	assign avg_new = FUEL_BITS'(ema_sum >> FRAC_W);

	// One quotient bit per cycle; the remainder always stays below the average.
	assign trial = {rem_q, dvd_q[LEFT_W-1]};
	assign diff  = trial - {1'b0, avg_q};
	assign fits  = (trial >= {1'b0, avg_q});

	assign st.primed    = primed_q;
	assign st.fuel_rise = (fuel_q > last_fuel_q);
	assign st.pit_exit  = refuel_q && (speed_q > pit_speed_q);
	assign st.new_lap   = (lap_q > last_lap_q);
	assign st.lap_drop  = (lap_start_q > fuel_q);
	assign st.avg_nz    = (avg_q != '0);
	// The quotient overflows 16 bits exactly when fuel >= average * 256.
	assign st.lap_sat   = ((FUEL_BITS + SAT_SH)'(fuel_q) >= {avg_q, SAT_SH'(0)});
	assign st.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ema_weight_q <= EMA_WEIGHT_RST;
			pit_speed_q  <= PIT_SPEED_RST;
			rate_q       <= RATE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EMA_WEIGHT:     ema_weight_q <= WEIGHT_W'(cfg_data);
				CFG_PIT_EXIT_SPEED: pit_speed_q  <= SPEED_W'(cfg_data);
				CFG_SAMPLE_RATE:    rate_q       <= RATE_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q    <= 1'b0;
			last_fuel_q <= '0;
			lap_start_q <= '0;
			last_lap_q  <= '0;
			refuel_q    <= 1'b0;
			avg_q       <= '0;
			left_q      <= '0;
			known_q     <= 1'b0;
		end else begin
			case (cmd.op)
				OP_FIRST: begin
					primed_q    <= 1'b1;
					last_fuel_q <= fuel_q;
					lap_start_q <= fuel_q;
					last_lap_q  <= lap_q;
					left_q      <= '0;
					known_q     <= 1'b0;
				end
				OP_REFUEL: begin
					refuel_q    <= 1'b1;
					last_fuel_q <= fuel_q;
				end
				OP_PIT_EXIT: begin
					refuel_q    <= 1'b0;
					lap_start_q <= fuel_q;
				end
				OP_LAP_SEED: begin
					avg_q       <= lap_d;
					lap_start_q <= fuel_q;
					last_lap_q  <= lap_q;
				end
				OP_LAP_CLOSE: begin
					lap_start_q <= fuel_q;
					last_lap_q  <= lap_q;
				end
				OP_EMA_DONE: begin
					avg_q       <= avg_new;
					lap_start_q <= fuel_q;
					last_lap_q  <= lap_q;
				end
				OP_LEFT_ZERO: begin
					left_q      <= '0;
					known_q     <= 1'b0;
					last_fuel_q <= fuel_q;
				end
				OP_LEFT_SAT: begin
					left_q      <= '1;
					known_q     <= 1'b1;
					last_fuel_q <= fuel_q;
				end
				OP_DIV_INIT: begin
					left_q      <= '0;
					known_q     <= 1'b1;
					last_fuel_q <= fuel_q;
				end
				OP_DIV_STEP: begin
					left_q <= {left_q[LEFT_W-2:0], fits};
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			fuel_q  <= in_data.fuel_level;
			speed_q <= in_data.speed;
			lap_q   <= in_data.lap_number;
		end
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (cmd.inst_take) begin
			inst_q <= INST_W'(prod_q);
		end
		case (cmd.op)
			OP_FIRST, OP_REFUEL: begin
				inst_q <= '0;
			end
			OP_EMA_ACC: begin
				acc_q <= prod_q;
			end
			OP_DIV_INIT: begin
				rem_q <= FUEL_BITS'(fuel_q >> SAT_SH);
				dvd_q <= LEFT_W'({fuel_q, FRAC_W'(0)});
			end
			OP_DIV_STEP: begin
				rem_q <= fits ? diff[FUEL_BITS-1:0] : trial[FUEL_BITS-1:0];
				dvd_q <= dvd_q << 1;
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			out_q.instant_use <= inst_q;
			out_q.lap_use     <= USE_W'(avg_q);
			out_q.laps_left   <= left_q;
			out_q.laps_known  <= known_q;
			out_q.refuelling  <= refuel_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

@@ hw/rtl/fple_checker.sv @@
// ----------------------------------------------------------------------------
// Estimator port checker
// Checks handshake behavior and result consistency on the top-level ports.
// ----------------------------------------------------------------------------
module fple_checker import fple_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_valid,
	input logic              s_ready,
	input logic              r_valid,
	input logic              r_ready,
	input logic [INST_W-1:0] r_inst,
	input logic [USE_W-1:0]  r_use,
	input logic [LEFT_W-1:0] r_left,
	input logic              r_known,
	input logic              r_refuel
);

	// A stalled result must not change.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable({r_inst, r_use, r_left, r_known, r_refuel}))
		else $error("result changed while stalled");

	// The block works on one sample at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready)
		else $error("sample accepted while busy");

	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_known |-> r_left == '0)
		else $error("laps left nonzero while unknown");

	// Without an average there can be no laps-left estimate.
	a_no_avg_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_use == '0 |-> !r_known)
		else $error("laps known without a lap average");

endmodule

bind fuel_per_lap_estimator fple_checker u_fple_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_valid  (sample.valid),
	.s_ready  (sample.ready),
	.r_valid  (result.valid),
	.r_ready  (result.ready),
	.r_inst   (result.data.instant_use),
	.r_use    (result.data.lap_use),
	.r_left   (result.data.laps_left),
	.r_known  (result.data.laps_known),
	.r_refuel (result.data.refuelling)
);

@@ sim/tb_fuel_per_lap_estimator.sv @@
// ----------------------------------------------------------------------------
// Fuel-per-lap estimator testbench
// Drives telemetry samples through the valid/ready sample channel. A short
// table of hand-picked samples comes first, then runs of lap-like traffic
// with pit stops and noise under several register settings. Every estimate
// is checked field by field: rows with chk set against the table, the rest
// against a predictor in this bench. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_fuel_per_lap_estimator;
	import fple_pkg::*;

	localparam int SETTLE_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int RANDOM_PER_PHASE = 255;
	localparam int PHASES           = 7;
	localparam int MAX_REPORTS      = 10;
	localparam logic [FUEL_BITS-1:0] FUEL_MAX = '1;

	typedef struct packed {
		logic [FUEL_BITS-1:0] fuel;
		logic [SPEED_W-1:0]   speed;
		logic [LAP_W-1:0]     lap;
		logic                 chk;
		logic [INST_W-1:0]    e_inst;
		logic [USE_W-1:0]     e_lap_use;
		logic [LEFT_W-1:0]    e_left;
		logic                 e_known;
		logic                 e_refl;
	} row_t;

	typedef struct packed {
		sample_t s;
		logic    chk;
		result_t exp;
	} sample_req_t;

	// Rows with chk set carry an estimate that can be read off directly.
	row_t directed_rows [14] = '{
		// First sample after reset, fuel at maximum.
		'{20'hFFFFF, 13'd0,    16'd0,     1'b1, 28'd0,     20'd0,    16'd0,     1'b0, 1'b0},
		// Steady fuel at top speed, no average yet.
		'{20'hFFFFF, 13'd8191, 16'd0,     1'b1, 28'd0,     20'd0,    16'd0,     1'b0, 1'b0},
		// First full lap seeds the average; laps left saturates.
		'{20'd1047551, 13'd1000, 16'd1,   1'b1, 28'd61440, 20'd1024, 16'd65535, 1'b1, 1'b0},
		// Tank drained to empty in one sample.
		'{20'd0,     13'd1000, 16'd1,     1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{20'd0,     13'd0,    16'd2,     1'b0, '0, '0, '0, 1'b0, 1'b0},
		// Refuel sample that also carries a lap change.
		'{20'hFFFFF, 13'd0,    16'd3,     1'b0, '0, '0, '0, 1'b0, 1'b0},
		// Speed equal to the threshold does not end the stop.
		'{20'hFFFFF, 13'd80,   16'd3,     1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{20'd1048000, 13'd81, 16'd3,     1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{20'd1040000, 13'd81, 16'd4,     1'b0, '0, '0, '0, 1'b0, 1'b0},
		// Lap counter going backwards is not a new lap.
		'{20'd1030000, 13'd3000, 16'd2,   1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{20'd1030000, 13'd3000, 16'd65535, 1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{20'd1020000, 13'd4000, 16'd0,   1'b0, '0, '0, '0, 1'b0, 1'b0},
		// Smallest possible rise, then exit at maximum speed.
		'{20'd1020001, 13'd0,    16'd0,   1'b0, '0, '0, '0, 1'b0, 1'b0},
		'{20'd1020001, 13'd8191, 16'd0,   1'b0, '0, '0, '0, 1'b0, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fple_sample_if sample_ch ();
	fple_result_if result_ch ();

	fuel_per_lap_estimator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register copies.
	logic [WEIGHT_W-1:0] cfg_weight;
	logic [SPEED_W-1:0]  cfg_pit_speed;
	logic [RATE_W-1:0]   cfg_rate;

	// Predictor state.
	logic                 est_primed;
	logic [FUEL_BITS-1:0] est_last_fuel;
	logic [FUEL_BITS-1:0] est_lap_start;
	logic [LAP_W-1:0]     est_last_lap;
	logic                 est_refuel;
	logic [FUEL_BITS-1:0] est_avg;
	logic [LEFT_W-1:0]    est_held_left;
	logic                 est_held_known;

	// Traffic generator state.
	int unsigned gen_fuel;
	logic [LAP_W-1:0] gen_lap;
	int unsigned gen_pit;
	bit gen_exit;

	sample_req_t sample_q [$];
	result_t     estimate_q [$];
	int          mismatch_count;
	int          idle_cycles = 0;
	bit          steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t predict_estimate(sample_t s);
		result_t r;
		logic [63:0] fuel;
		logic [63:0] d;
		logic [63:0] w;
		logic [63:0] quot;
		r = '0;
		fuel = 64'(s.fuel_level);
		if (!est_primed) begin
			est_primed = 1'b1;
			est_last_fuel = s.fuel_level;
			est_lap_start = s.fuel_level;
			est_last_lap = s.lap_number;
			est_held_left = '0;
			est_held_known = 1'b0;
			return r;
		end
		if (s.fuel_level > est_last_fuel) begin
			// Refuel sample: repeat the held estimate, lap changes wait.
			est_refuel = 1'b1;
			est_last_fuel = s.fuel_level;
			r.lap_use = USE_W'(est_avg);
			r.laps_left = est_held_left;
			r.laps_known = est_held_known;
			r.refuelling = 1'b1;
			return r;
		end
		if (est_refuel && s.speed > cfg_pit_speed) begin
			est_refuel = 1'b0;
			est_lap_start = s.fuel_level;
		end
		r.instant_use = INST_W'((64'(est_last_fuel) - fuel) * 64'(cfg_rate));
		if (s.lap_number > est_last_lap) begin
			if (est_lap_start > s.fuel_level) begin
				d = 64'(est_lap_start) - fuel;
				if (est_avg == '0) begin
					est_avg = FUEL_BITS'(d);
				end else begin
					w = (cfg_weight > 9'd256) ? 64'd256 : 64'(cfg_weight);
					est_avg = FUEL_BITS'((64'(est_avg) * (64'd256 - w) + d * w + 64'd128) >> 8);
				end
			end
			est_lap_start = s.fuel_level;
			est_last_lap = s.lap_number;
		end
		if (est_avg != '0) begin
			quot = (fuel << 8) / 64'(est_avg);
			r.laps_left = (quot > 64'hFFFF) ? '1 : LEFT_W'(quot);
			r.laps_known = 1'b1;
		end
		est_held_left = r.laps_left;
		est_held_known = r.laps_known;
		est_last_fuel = s.fuel_level;
		r.lap_use = USE_W'(est_avg);
		r.refuelling = est_refuel;
		return r;
	endfunction

	// Mostly lap-like traffic: steady drops, lap ticks, pit stops that end above
	// the exit speed (or at a maximal one) and a share of fully random samples.
	function automatic sample_t gen_sample();
		sample_t s;
		int unsigned r;
		int unsigned drop;
		r = $urandom_range(0, 99);
		s.speed = SPEED_W'($urandom_range(0, 8191));
		if (r < 7) begin
			s.fuel_level = FUEL_BITS'($urandom);
			s.lap_number = LAP_W'($urandom);
			return s;
		end
		if (gen_pit > 0) begin
			gen_pit--;
			gen_fuel = gen_fuel + $urandom_range(1, 40000);
			if (gen_fuel > FUEL_MAX) gen_fuel = FUEL_MAX;
			s.speed = SPEED_W'($urandom_range(0, cfg_pit_speed));
		end else if (gen_exit) begin
			gen_exit = 1'b0;
			s.speed = (cfg_pit_speed == '1) ? '1 :
				SPEED_W'($urandom_range(cfg_pit_speed + 1, 8191));
		end else begin
			if (gen_fuel < 20000 || r < 10) begin
				gen_pit = $urandom_range(1, 6);
				gen_exit = 1'b1;
			end
			drop = $urandom_range(0, 400);
			gen_fuel = (gen_fuel > drop) ? gen_fuel - drop : 0;
		end
		if ($urandom_range(0, 9) == 0)
			gen_lap = gen_lap + (($urandom_range(0, 7) == 0) ? 16'd2 : 16'd1);
		s.fuel_level = FUEL_BITS'(gen_fuel);
		s.lap_number = gen_lap;
		return s;
	endfunction

	function automatic int draw_gap();
		return steady ? 0 : int'($urandom_range(0, 3));
	endfunction

	task automatic note_failure(input string what, input logic [31:0] e, input logic [31:0] a);
		if (mismatch_count < MAX_REPORTS)
			$display("mismatch %s: expected %0d, got %0d", what, e, a);
		mismatch_count++;
	endtask

	task automatic wait_idle();
		while (estimate_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(input logic [WEIGHT_W-1:0] w, input logic [SPEED_W-1:0] pit,
			input logic [RATE_W-1:0] rate);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_EMA_WEIGHT;
		cfg_data <= CFG_DATA_W'(w);
		@(posedge clk);
		cfg_index <= CFG_PIT_EXIT_SPEED;
		cfg_data <= CFG_DATA_W'(pit);
		@(posedge clk);
		cfg_index <= CFG_SAMPLE_RATE;
		cfg_data <= CFG_DATA_W'(rate);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_weight = w;
		cfg_pit_speed = pit;
		cfg_rate = rate;
	endtask

	// Valid stays high across back-to-back requests and drops only before a gap or after the last request.
	task automatic send_batch();
		sample_req_t req;
		result_t exp;
		int gap;
		int sent;
		sent = 0;
		gap = draw_gap();
		while (sample_q.size() != 0) begin
			req = sample_q.pop_front();
			repeat (gap) @(posedge clk);
			sample_ch.valid <= 1'b1;
			sample_ch.data <= req.s;
			@(posedge clk);
			while (!sample_ch.ready) @(posedge clk);
			exp = predict_estimate(req.s);
			estimate_q.push_back(req.chk ? req.exp : exp);
			sent++;
			if (sent % 40 == 0) steady = ($urandom_range(0, 3) == 0);
			gap = draw_gap();
			if (gap > 0 || sample_q.size() == 0) sample_ch.valid <= 1'b0;
		end
	endtask

	task automatic start_traffic();
		gen_fuel = $urandom_range(200000, 1048575);
		gen_lap = $urandom_range(0, 1) ? LAP_W'($urandom_range(65528, 65535)) :
			LAP_W'($urandom_range(0, 100));
		gen_pit = 0;
		gen_exit = 1'b0;
	endtask

	// Result side.
	initial begin
		result_t exp;
		result_t got;
		int gap;
		result_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			got = result_ch.data;
			if (estimate_q.size() == 0) begin
				note_failure("unrequested estimate", 0, 1);
			end else begin
				exp = estimate_q.pop_front();
				if (got.instant_use !== exp.instant_use)
					note_failure("instant_use", 32'(exp.instant_use), 32'(got.instant_use));
				if (got.lap_use !== exp.lap_use)
					note_failure("lap_use", 32'(exp.lap_use), 32'(got.lap_use));
				if (got.laps_left !== exp.laps_left)
					note_failure("laps_left", 32'(exp.laps_left), 32'(got.laps_left));
				if (got.laps_known !== exp.laps_known)
					note_failure("laps_known", 32'(exp.laps_known), 32'(got.laps_known));
				if (got.refuelling !== exp.refuelling)
					note_failure("refuelling", 32'(exp.refuelling), 32'(got.refuelling));
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		sample_req_t req;
		logic [WEIGHT_W-1:0] w;
		logic [SPEED_W-1:0] pit;
		logic [RATE_W-1:0] rate;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.data <= '0;
		mismatch_count = 0;
		steady = 1'b0;
		cfg_weight = EMA_WEIGHT_RST;
		cfg_pit_speed = PIT_SPEED_RST;
		cfg_rate = RATE_RST;
		est_primed = 1'b0;
		est_last_fuel = '0;
		est_lap_start = '0;
		est_last_lap = '0;
		est_refuel = 1'b0;
		est_avg = '0;
		est_held_left = '0;
		est_held_known = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			req.s.fuel_level = directed_rows[i].fuel;
			req.s.speed = directed_rows[i].speed;
			req.s.lap_number = directed_rows[i].lap;
			req.chk = directed_rows[i].chk;
			req.exp.instant_use = directed_rows[i].e_inst;
			req.exp.lap_use = directed_rows[i].e_lap_use;
			req.exp.laps_left = directed_rows[i].e_left;
			req.exp.laps_known = directed_rows[i].e_known;
			req.exp.refuelling = directed_rows[i].e_refl;
			sample_q.push_back(req);
		end
		send_batch();

		// Phase 0 keeps the reset settings; later phases cover the extremes,
		// a weight above one, a zero sample rate, random settings and a half weight.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: write_settings(9'd0, 13'd0, 8'd1);
				2: write_settings(WEIGHT_ONE, 13'd8191, 8'd255);
				3: write_settings(9'd511, 13'd4095, 8'd0);
				4, 5: begin
					w = WEIGHT_W'($urandom_range(0, 511));
					pit = SPEED_W'($urandom_range(0, 400));
					rate = RATE_W'($urandom_range(0, 255));
					write_settings(w, pit, rate);
				end
				6: write_settings(9'd128, 13'd80, 8'd60);
				default: ;
			endcase
			start_traffic();
			repeat (RANDOM_PER_PHASE) begin
				req.s = gen_sample();
				req.chk = 1'b0;
				req.exp = '0;
				sample_q.push_back(req);
			end
			send_batch();
		end

		wait_idle();
		if (mismatch_count == 0 && estimate_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/fple_pkg.sv
hw/rtl/fple_sample_if.sv
hw/rtl/fple_result_if.sv
hw/rtl/fple_ctrl.sv
hw/rtl/fple_dp.sv
hw/rtl/fuel_per_lap_estimator.sv
hw/rtl/fple_checker.sv
sim/tb_fuel_per_lap_estimator.sv
